/* design/itar_pkg.sv */
package itar_pkg;

  // Width of the number being printed
  localparam int VALUE_BITS = 32;

  // Divider: bits retired per clock and clocks per digit
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QUO_BITS   = DIV_CYCLES * DIV_STEPS;
  localparam int SC_BITS    = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Digit store: one slot per possible base-two digit
  localparam int DIGIT_SLOTS = VALUE_BITS;
  localparam int IDX_BITS    = $clog2(DIGIT_SLOTS);
  localparam int CNT_BITS    = $clog2(DIGIT_SLOTS + 1);

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Radix codes
  localparam logic [5:0] RADIX_RAW = 6'd0;
  localparam logic [5:0] RADIX_ONE = 6'd1;
  localparam logic [5:0] RADIX_TEN = 6'd10;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            radix;
    logic                  is_signed;
    logic                  add_newline;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } res_t;

  // Classified request as handed from front to back
  typedef struct packed {
    logic                  raw;
    logic                  negative;
    logic                  is_zero;
    logic                  newline;
    logic [5:0]            base;
    logic [VALUE_BITS-1:0] magnitude;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_HEAD,
    BK_DIVIDE,
    BK_FETCH,
    BK_EMIT,
    BK_CR,
    BK_LF
  } back_state_t;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = CHAR_ZERO + {2'b00, d};
    end else begin
      c = CHAR_A + {2'b00, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* design/itar_ram.sv */
module itar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/itar_front.sv */
module itar_front (
  input  logic                 start,
  input  itar_pkg::queue_status_t status,
  input  itar_pkg::req_t       request,
  output logic                 push,
  output itar_pkg::cmd_t       cmd
);
  import itar_pkg::*;

  logic [5:0] base;
  logic       negative;

  // Take a request whenever the queue has room
  assign push = start && !status.full;

  // Fold base one into base ten and pick out the minus-sign case
  assign base     = (request.radix == RADIX_ONE) ? RADIX_TEN : request.radix;
  assign negative = (base == RADIX_TEN) && request.is_signed
                    && request.value[VALUE_BITS-1];

  always_comb begin
    cmd.raw       = (request.radix == RADIX_RAW);
    cmd.negative  = negative;
    cmd.is_zero   = (request.value == '0);
    cmd.newline   = request.add_newline;
    cmd.base      = base;
    cmd.magnitude = negative ? (~request.value + VALUE_BITS'(1)) : request.value;
  end

endmodule

/* design/itar_queue.sv */
module itar_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  itar_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output itar_pkg::cmd_t          head,
  output itar_pkg::queue_status_t status
);
  import itar_pkg::*;

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* design/itar_back.sv */
module itar_back (
  input  logic                    clk,
  input  logic                    rst,
  input  itar_pkg::queue_status_t status,
  input  itar_pkg::cmd_t          head,
  output logic                    pop,
  output logic                    strobe,
  output itar_pkg::res_t          result
);
  import itar_pkg::*;

  back_state_t state, state_next;

  cmd_t                job;
  logic [QUO_BITS-1:0] quo;
  logic [5:0]          rem;
  logic [SC_BITS-1:0]  sc;
  logic [CNT_BITS-1:0] digit_count;

  logic [QUO_BITS-1:0] quo_next;
  logic [5:0]          rem_next;
  logic                digit_done;
  logic                strobe_next;
  res_t                result_next;

  logic [CNT_BITS-1:0] cnt_m1;
  logic [CNT_BITS-1:0] cnt_m2;
  logic [CNT_BITS-1:0] rd_cnt;
  logic [5:0]          rd_digit;

  // Divider: retire DIV_STEPS quotient bits per clock
  always_comb begin
    logic [5:0] r;
    logic [QUO_BITS-1:0] q;
    logic [6:0] t;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, q[QUO_BITS-1]};
      q = {q[QUO_BITS-2:0], 1'b0};
      if (t >= {1'b0, job.base}) begin
        r    = 6'(t - {1'b0, job.base});
        q[0] = 1'b1;
      end else begin
        r = t[5:0];
      end
    end
    quo_next = q;
    rem_next = r;
  end

  assign digit_done = (state == BK_DIVIDE) && (sc == SC_BITS'(DIV_CYCLES - 1));

  // Digit store addressing: read one ahead while emitting
  assign cnt_m1 = digit_count - CNT_BITS'(1);
  assign cnt_m2 = digit_count - CNT_BITS'(2);
  assign rd_cnt = (state == BK_EMIT) ? cnt_m2 : cnt_m1;

  itar_ram #(
    .WIDTH(6),
    .DEPTH(DIGIT_SLOTS)
  ) u_digit_store (
    .clk  (clk),
    .we   (digit_done),
    .waddr(digit_count[IDX_BITS-1:0]),
    .wdata(rem_next),
    .raddr(rd_cnt[IDX_BITS-1:0]),
    .rdata(rd_digit)
  );

  assign pop = (state == BK_IDLE) && !status.empty;

  // Sequencer: next state and the character to send
  always_comb begin
    state_next            = state;
    strobe_next           = 1'b0;
    result_next.character = CHAR_ZERO;
    result_next.last      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!status.empty) begin
          state_next = BK_HEAD;
        end
      end
      BK_HEAD: begin
        if (job.raw) begin
          strobe_next           = 1'b1;
          result_next.character = job.magnitude[7:0];
          result_next.last      = !job.newline;
          state_next            = job.newline ? BK_CR : BK_IDLE;
        end else if (job.negative) begin
          strobe_next           = 1'b1;
          result_next.character = CHAR_MINUS;
          state_next            = BK_DIVIDE;
        end else if (job.is_zero) begin
          strobe_next           = 1'b1;
          result_next.character = CHAR_ZERO;
          result_next.last      = !job.newline;
          state_next            = job.newline ? BK_CR : BK_IDLE;
        end else begin
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (digit_done && (quo_next[VALUE_BITS-1:0] == '0)) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        strobe_next           = 1'b1;
        result_next.character = digit_char(rd_digit);
        if (digit_count == CNT_BITS'(1)) begin
          result_next.last = !job.newline;
          state_next       = job.newline ? BK_CR : BK_IDLE;
        end
      end
      BK_CR: begin
        strobe_next           = 1'b1;
        result_next.character = CHAR_CR;
        state_next            = BK_LF;
      end
      BK_LF: begin
        strobe_next           = 1'b1;
        result_next.character = CHAR_LF;
        result_next.last      = 1'b1;
        state_next            = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // State, output strobe, digit count and divider step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      strobe      <= 1'b0;
      digit_count <= '0;
      sc          <= '0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (pop) begin
        digit_count <= '0;
        sc          <= '0;
      end else if (digit_done) begin
        digit_count <= digit_count + 1'b1;
        sc          <= '0;
      end else if (state == BK_DIVIDE) begin
        sc <= sc + 1'b1;
      end else if (state == BK_EMIT) begin
        digit_count <= cnt_m1;
      end
    end
  end

  // Datapath: load the job, then hold or advance the quotient
  always_ff @(posedge clk) begin
    result <= result_next;
    if (pop) begin
      job <= head;
      quo <= QUO_BITS'(head.magnitude);
      rem <= '0;
    end else if (digit_done) begin
      quo <= quo_next;
      rem <= '0;
    end else if (state == BK_DIVIDE) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

/* design/integer_to_ascii_radix.sv */
// Prints one number per request as ASCII characters, most significant digit
// first, with an optional leading '-' (signed base ten) and trailing CR LF.
// Characters leave one per cycle on result, pausing while the divider works,
// each marked by strobe for exactly one clock; the receiver cannot hold them
// off, so it must take every strobe. A request is taken when start is high and
// busy is low; up to two requests wait in a queue while the back end prints,
// and busy is high while it is full. A request picked up by the back end goes
// from the idle state to the head state, which sends a raw byte, a zero or the
// minus sign; the divider, which retires eight quotient bits per clock, then
// writes a number's digits one by one into a digit store that a fetch state
// primes before the digits go out, then CR LF. Base two gives up to 32 digits.
module integer_to_ascii_radix (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  itar_pkg::req_t request,
  output logic           strobe,
  output itar_pkg::res_t result
);
  import itar_pkg::*;

  queue_status_t status;
  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;

  assign busy = status.full;

  itar_front u_front (
    .start  (start),
    .status (status),
    .request(request),
    .push   (push),
    .cmd    (push_cmd)
  );

  itar_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .status  (status)
  );

  itar_back u_back (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .head  (head),
    .pop   (pop),
    .strobe(strobe),
    .result(result)
  );

endmodule

/* design/itar_checker.sv */
module itar_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input itar_pkg::req_t request,
  input logic           strobe,
  input itar_pkg::res_t result
);
  import itar_pkg::*;

  // No character and no back-pressure straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("strobe or busy set after reset");

  // The queue only fills on a request
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // Within a request, characters run back to back except after the sign
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last && (result.character != CHAR_MINUS) |=> strobe)
    else $error("gap inside a run of characters");

  // A lone raw request with no recent start, strobe or busy finds busy low
  a_first_char: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.radix == RADIX_RAW) && !$past(busy) && !strobe
    && !$past(strobe) && !$past(start) && !$past(strobe, 2) && !$past(start, 2)
    |-> !busy)
    else $error("queue full on a lone request");

endmodule

bind integer_to_ascii_radix itar_checker u_checker (.*);
